// ----- sv/doubly_linked_list_engine_assert.svh -----
// Assertion macros for the doubly linked list engine checker.
// Needs clk_i and rst_ni in scope where a macro is used.
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DLLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DLLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dlle_pkg.sv -----
// Shared types, constants and codes of the doubly linked list engine.
// No dependencies; every other file but dlle_ram and the assertion header refers to it by scoped names.
`timescale 1ns / 1ps

package dlle_pkg;

  localparam int ENTRIES  = 64;
  localparam int NODES    = ENTRIES + 2;
  localparam int NODE_W   = $clog2(NODES);
  localparam int FREE_W   = $clog2(NODES + 1);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [NODE_W-1:0] HEAD_NODE = NODE_W'(0);
  localparam logic [NODE_W-1:0] TAIL_NODE = NODE_W'(1);

  localparam logic [MODE_W-1:0] MODE_INS_HEAD  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_INS_TAIL  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_DELETE    = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_INS_LEFT  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_INS_RIGHT = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_LIST      = MODE_W'(5);

  localparam logic [STATUS_W-1:0] STAT_OK   = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_FULL = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_BAD  = STATUS_W'(2);

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      is_element;
    logic                      empty_res;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_NODE,
    S_INS_LINK,
    S_DEL,
    S_LIST_FIRST,
    S_LIST_WALK
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ITEM,
    RD_NEXT
  } rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_NODE,
    WR_LINK,
    WR_DEL
  } wr_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_FULL,
    EM_BAD,
    EM_EMPTY,
    EM_ELEM
  } emit_e;

  typedef struct packed {
    logic  load;
    rd_e   rd;
    wr_e   wr;
    emit_e emit;
    logic  cnt_clr;
    logic  cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              idx_bad;
    logic              full;
    logic              first_tail;
    logic              walk_last;
  } sts_t;

endpackage

// ----- sv/dlle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dlle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/dlle_ctrl.sv -----
// Controller of the doubly linked list engine: sequences each transaction.
// Depends on dlle_pkg; drives commands to dlle_dp and reads its status.
`timescale 1ns / 1ps

module dlle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  dlle_pkg::sts_t sts_i,
  output dlle_pkg::cmd_t cmd_o
);

  dlle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlle_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != dlle_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dlle_pkg::S_IDLE: begin
        if (start_i) state_d = dlle_pkg::S_CHECK;
      end
      dlle_pkg::S_CHECK: begin
        case (sts_i.mode)
          dlle_pkg::MODE_INS_HEAD, dlle_pkg::MODE_INS_TAIL: begin
            state_d = sts_i.full ? dlle_pkg::S_IDLE : dlle_pkg::S_INS_NODE;
          end
          dlle_pkg::MODE_DELETE: begin
            state_d = sts_i.idx_bad ? dlle_pkg::S_IDLE : dlle_pkg::S_DEL;
          end
          dlle_pkg::MODE_INS_LEFT, dlle_pkg::MODE_INS_RIGHT: begin
            state_d = (sts_i.idx_bad || sts_i.full) ? dlle_pkg::S_IDLE
                                                    : dlle_pkg::S_INS_NODE;
          end
          dlle_pkg::MODE_LIST: state_d = dlle_pkg::S_LIST_FIRST;
          default:             state_d = dlle_pkg::S_IDLE;
        endcase
      end
      dlle_pkg::S_INS_NODE: state_d = dlle_pkg::S_INS_LINK;
      dlle_pkg::S_INS_LINK: state_d = dlle_pkg::S_IDLE;
      dlle_pkg::S_DEL:      state_d = dlle_pkg::S_IDLE;
      dlle_pkg::S_LIST_FIRST: begin
        state_d = sts_i.first_tail ? dlle_pkg::S_IDLE : dlle_pkg::S_LIST_WALK;
      end
      dlle_pkg::S_LIST_WALK: begin
        if (sts_i.walk_last) state_d = dlle_pkg::S_IDLE;
      end
      default: state_d = dlle_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.load    = 1'b0;
    cmd_o.rd      = dlle_pkg::RD_NONE;
    cmd_o.wr      = dlle_pkg::WR_NONE;
    cmd_o.emit    = dlle_pkg::EM_NONE;
    cmd_o.cnt_clr = 1'b0;
    cmd_o.cnt_inc = 1'b0;
    case (state_q)
      dlle_pkg::S_IDLE: cmd_o.load = start_i;
      dlle_pkg::S_CHECK: begin
        case (sts_i.mode)
          dlle_pkg::MODE_INS_HEAD, dlle_pkg::MODE_INS_TAIL: begin
            if (sts_i.full) cmd_o.emit = dlle_pkg::EM_FULL;
            else            cmd_o.rd   = dlle_pkg::RD_ITEM;
          end
          dlle_pkg::MODE_DELETE: begin
            if (sts_i.idx_bad) cmd_o.emit = dlle_pkg::EM_BAD;
            else               cmd_o.rd   = dlle_pkg::RD_ITEM;
          end
          dlle_pkg::MODE_INS_LEFT, dlle_pkg::MODE_INS_RIGHT: begin
            // index check takes priority over the full check
            if (sts_i.idx_bad)   cmd_o.emit = dlle_pkg::EM_BAD;
            else if (sts_i.full) cmd_o.emit = dlle_pkg::EM_FULL;
            else                 cmd_o.rd   = dlle_pkg::RD_ITEM;
          end
          dlle_pkg::MODE_LIST: cmd_o.rd   = dlle_pkg::RD_ITEM;
          default:             cmd_o.emit = dlle_pkg::EM_OK;
        endcase
      end
      dlle_pkg::S_INS_NODE: cmd_o.wr = dlle_pkg::WR_NODE;
      dlle_pkg::S_INS_LINK: begin
        cmd_o.wr   = dlle_pkg::WR_LINK;
        cmd_o.emit = dlle_pkg::EM_OK;
      end
      dlle_pkg::S_DEL: begin
        cmd_o.wr   = dlle_pkg::WR_DEL;
        cmd_o.emit = dlle_pkg::EM_OK;
      end
      dlle_pkg::S_LIST_FIRST: begin
        if (sts_i.first_tail) begin
          cmd_o.emit = dlle_pkg::EM_EMPTY;
        end else begin
          cmd_o.rd      = dlle_pkg::RD_NEXT;
          cmd_o.cnt_clr = 1'b1;
        end
      end
      dlle_pkg::S_LIST_WALK: begin
        cmd_o.emit = dlle_pkg::EM_ELEM;
        if (!sts_i.walk_last) begin
          cmd_o.rd      = dlle_pkg::RD_NEXT;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

endmodule

// ----- sv/dlle_dp.sv -----
// Datapath of the doubly linked list engine: link and value memories,
// presence flags, free-slot pointer and result register. Uses dlle_pkg, dlle_ram.
`timescale 1ns / 1ps

module dlle_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dlle_pkg::item_t item_i,
  input  dlle_pkg::cmd_t  cmd_i,
  output dlle_pkg::sts_t  sts_o,
  output logic            res_valid_o,
  output dlle_pkg::res_t  res_o
);

  localparam int CMP_W = ((dlle_pkg::SLOT_W > dlle_pkg::FREE_W) ? dlle_pkg::SLOT_W
                                                                : dlle_pkg::FREE_W) + 2;

  // item registers
  logic [dlle_pkg::MODE_W-1:0]         mode_q;
  logic [dlle_pkg::SLOT_W-1:0]         slot_q;
  logic signed [dlle_pkg::VALUE_W-1:0] value_q;

  // list state
  logic [dlle_pkg::FREE_W-1:0] nfree_q;
  logic [dlle_pkg::NODES-1:0]  present_q;
  logic                        hr_vld_q, tl_vld_q;
  logic                        lfix_q, rfix_q;
  logic [dlle_pkg::NODE_W-1:0] p_q, q_q, p_d, q_d;
  logic [dlle_pkg::CNT_W-1:0]  cnt_q;

  logic                        res_valid_q;
  dlle_pkg::res_t              res_q, res_d;

  // memory ports
  logic                         l_we, r_we, v_we;
  logic [dlle_pkg::NODE_W-1:0]  l_wa, l_wd, r_wa, r_wd, l_ra, r_ra;
  logic [dlle_pkg::NODE_W-1:0]  l_rd, r_rd;
  logic [dlle_pkg::VALUE_W-1:0] v_rd;

  logic [dlle_pkg::SLOT_W:0]   slot_p1;
  logic [dlle_pkg::NODE_W-1:0] node_n, nf, rleft, rright;
  logic                        slot_ok, node_live;

  dlle_ram #(.WIDTH(dlle_pkg::NODE_W), .DEPTH(dlle_pkg::NODES)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_wa),
    .wdata_i(l_wd),
    .raddr_i(l_ra),
    .rdata_o(l_rd)
  );

  dlle_ram #(.WIDTH(dlle_pkg::NODE_W), .DEPTH(dlle_pkg::NODES)) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_wa),
    .wdata_i(r_wd),
    .raddr_i(r_ra),
    .rdata_o(r_rd)
  );

  dlle_ram #(.WIDTH(dlle_pkg::VALUE_W), .DEPTH(dlle_pkg::NODES)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(nf),
    .wdata_i(value_q),
    .raddr_i(r_ra),
    .rdata_o(v_rd)
  );

  // entry k lives in node k+1
  assign slot_p1 = {1'b0, slot_q} + (dlle_pkg::SLOT_W + 1)'(1);
  assign node_n  = dlle_pkg::NODE_W'(slot_p1);
  assign nf      = dlle_pkg::NODE_W'(nfree_q);
  assign slot_ok = (slot_q != '0) &&
                   ((CMP_W'(slot_q) + CMP_W'(2)) <= CMP_W'(nfree_q));
  assign node_live = slot_ok ? present_q[node_n] : 1'b0;

  // sentinel links read as their reset value until first written
  assign rleft  = lfix_q ? dlle_pkg::HEAD_NODE : l_rd;
  assign rright = rfix_q ? dlle_pkg::TAIL_NODE : r_rd;

  assign sts_o.mode       = mode_q;
  assign sts_o.idx_bad    = !node_live;
  assign sts_o.full       = (nfree_q >= dlle_pkg::FREE_W'(dlle_pkg::NODES));
  assign sts_o.first_tail = (rright == dlle_pkg::TAIL_NODE);
  assign sts_o.walk_last  = (rright == dlle_pkg::TAIL_NODE) ||
                            (cnt_q == dlle_pkg::CNT_W'(dlle_pkg::ENTRIES - 1));

  // read addresses
  always_comb begin
    l_ra = (mode_q == dlle_pkg::MODE_INS_TAIL) ? dlle_pkg::TAIL_NODE : node_n;
    if (cmd_i.rd == dlle_pkg::RD_NEXT) begin
      r_ra = rright;
    end else if (mode_q == dlle_pkg::MODE_INS_HEAD || mode_q == dlle_pkg::MODE_LIST) begin
      r_ra = dlle_pkg::HEAD_NODE;
    end else begin
      r_ra = node_n;
    end
  end

  // neighbours of the new node; a live node's neighbours point back at it
  always_comb begin
    case (mode_q)
      dlle_pkg::MODE_INS_HEAD: begin
        p_d = dlle_pkg::HEAD_NODE;
        q_d = rright;
      end
      dlle_pkg::MODE_INS_TAIL: begin
        p_d = rleft;
        q_d = dlle_pkg::TAIL_NODE;
      end
      dlle_pkg::MODE_INS_LEFT: begin
        p_d = rleft;
        q_d = node_n;
      end
      default: begin
        p_d = node_n;
        q_d = rright;
      end
    endcase
  end

  // writes
  always_comb begin
    l_we = 1'b0;
    r_we = 1'b0;
    v_we = 1'b0;
    l_wa = nf;
    l_wd = p_d;
    r_wa = nf;
    r_wd = q_d;
    case (cmd_i.wr)
      dlle_pkg::WR_NODE: begin
        l_we = 1'b1;
        r_we = 1'b1;
        v_we = 1'b1;
      end
      dlle_pkg::WR_LINK: begin
        l_we = 1'b1;
        r_we = 1'b1;
        l_wa = q_q;
        l_wd = nf;
        r_wa = p_q;
        r_wd = nf;
      end
      dlle_pkg::WR_DEL: begin
        // unlink: right of a goes to b, left of b goes to a
        l_we = 1'b1;
        r_we = 1'b1;
        r_wa = rleft;
        r_wd = rright;
        l_wa = rright;
        l_wd = rleft;
      end
      default: l_we = 1'b0;
    endcase
  end

  // result
  always_comb begin
    res_d.status     = dlle_pkg::STAT_OK;
    res_d.is_element = 1'b0;
    res_d.empty_res  = 1'b0;
    res_d.element    = '0;
    res_d.last       = 1'b1;
    case (cmd_i.emit)
      dlle_pkg::EM_FULL:  res_d.status    = dlle_pkg::STAT_FULL;
      dlle_pkg::EM_BAD:   res_d.status    = dlle_pkg::STAT_BAD;
      dlle_pkg::EM_EMPTY: res_d.empty_res = 1'b1;
      dlle_pkg::EM_ELEM: begin
        res_d.is_element = 1'b1;
        res_d.element    = v_rd;
        res_d.last       = sts_o.walk_last;
      end
      default: res_d.status = dlle_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfree_q     <= dlle_pkg::FREE_W'(2);
      present_q   <= '0;
      hr_vld_q    <= 1'b0;
      tl_vld_q    <= 1'b0;
      lfix_q      <= 1'b0;
      rfix_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      lfix_q      <= (l_ra == dlle_pkg::TAIL_NODE) && !tl_vld_q;
      rfix_q      <= (r_ra == dlle_pkg::HEAD_NODE) && !hr_vld_q;
      res_valid_q <= (cmd_i.emit != dlle_pkg::EM_NONE);
      if (l_we && l_wa == dlle_pkg::TAIL_NODE) tl_vld_q <= 1'b1;
      if (r_we && r_wa == dlle_pkg::HEAD_NODE) hr_vld_q <= 1'b1;
      if (cmd_i.wr == dlle_pkg::WR_LINK) begin
        present_q[nf] <= 1'b1;
        nfree_q       <= nfree_q + dlle_pkg::FREE_W'(1);
      end
      if (cmd_i.wr == dlle_pkg::WR_DEL) begin
        present_q[node_n] <= 1'b0;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + dlle_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= item_i.mode;
      slot_q  <= item_i.slot;
      value_q <= item_i.value;
    end
    if (cmd_i.wr == dlle_pkg::WR_NODE) begin
      p_q <= p_d;
      q_q <= q_d;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/doubly_linked_list_engine.sv -----
// Top level; uses dlle_pkg, dlle_ctrl and dlle_dp. The result is registered and follows the
// controller's last state: link write for an insert, unlink for a delete, check for a
// rejected request or an unused mode; a list gives its N elements one per cycle, following the right links.
// The next transaction is taken at the edge that ends the final result's cycle; results
// cannot be held off, so nothing stalls.
// Reset is asynchronous active low and leaves an empty list, ready at once.
`timescale 1ns / 1ps

module doubly_linked_list_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dlle_pkg::item_t item_i,
  output logic            res_valid_o,
  output dlle_pkg::res_t  res_o
);

  dlle_pkg::cmd_t cmd;
  dlle_pkg::sts_t sts;

  dlle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dlle_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ----- sv/dlle_chk.sv -----
// Port-level checker for the doubly linked list engine, bound to the top level.
// Uses dlle_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_assert.svh"

module dlle_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input dlle_pkg::res_t res_o
);

  `DLLE_ASSERT_IMP(a_err_is_last, res_valid_o && (res_o.status != dlle_pkg::STAT_OK), res_o.last, "error status on a non-final result")
  `DLLE_ASSERT_IMP(a_elem_clean, res_valid_o && res_o.is_element, (res_o.status == dlle_pkg::STAT_OK) && !res_o.empty_res, "element result with status or empty flag")
  `DLLE_ASSERT_IMP(a_last_frees, res_valid_o && res_o.last, !busy, "still busy after final result")
  `DLLE_ASSERT_IMP(a_more_busy, res_valid_o && !res_o.last, busy, "idle with results outstanding")
  `DLLE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "not busy after accepting a transaction")

endmodule

bind doubly_linked_list_engine dlle_chk u_dlle_chk (.*);
